[rtl/core/drm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense id remapper package
// Shared field widths, action codes and the sequencer state type.
// ----------------------------------------------------------------------------
package drm_pkg;

	localparam int unsigned ActionWidth     = 2;
	localparam int unsigned BoneIdWidth     = 16;
	localparam int unsigned DenseIdWidth    = 8;
	localparam int unsigned EntryCountWidth = 9;

	typedef logic [ActionWidth-1:0]     action_t;
	typedef logic [BoneIdWidth-1:0]     bone_id_t;
	typedef logic [DenseIdWidth-1:0]    dense_id_t;
	typedef logic [EntryCountWidth-1:0] entry_count_t;

	// Action code 3 carries no name of its own; it behaves like a lookup.
	localparam action_t ACT_CLEAR  = 2'd0;
	localparam action_t ACT_REMAP  = 2'd1;
	localparam action_t ACT_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} drm_state_t;

endpackage

[rtl/core/drm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense id remapper request channel
// Valid/ready channel that carries one action and one source identifier.
// ----------------------------------------------------------------------------
interface drm_req_if;

	logic              valid;
	logic              ready;
	drm_pkg::action_t  action;
	drm_pkg::bone_id_t bone_id;

	modport source (output valid, output action, output bone_id, input ready);
	modport sink   (input valid, input action, input bone_id, output ready);

endinterface

[rtl/core/drm_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense id remapper response channel
// Valid/ready channel that carries one clear, remap or lookup result.
// ----------------------------------------------------------------------------
interface drm_rsp_if;

	logic                  valid;
	logic                  ready;
	drm_pkg::dense_id_t    dense_id;
	logic                  found;
	logic                  was_new;
	logic                  overflow;
	drm_pkg::entry_count_t entry_count;

	modport source (
		output valid, output dense_id, output found, output was_new,
		output overflow, output entry_count, input ready
	);
	modport sink (
		input valid, input dense_id, input found, input was_new,
		input overflow, input entry_count, output ready
	);

endinterface

[rtl/core/dense_id_remapper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense id remapper
// A clear beat goes straight to the result stage; a remap or lookup beat first
// scans the filled entries until a match or until every one has been compared.
// Only one beat is in flight; the next is taken the cycle after the result is
// registered, and the result stage waits while a held output register is full.
// Reset clears the entry count, the overflow flag and all handshake state.
// The identifier table needs no clearing pass: only filled entries are read.
// ----------------------------------------------------------------------------
module dense_id_remapper_top #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	drm_req_if.sink   req,
	drm_rsp_if.source rsp
);

	// Index bits address the table; count bits hold zero up to the depth itself.
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	// Identifier table: position i holds the identifier whose dense id is i.
	drm_pkg::bone_id_t id_mem [TABLE_DEPTH];

	drm_pkg::drm_state_t state_q, state_d;

	// Captured request beat.
	drm_pkg::action_t  act_q;
	drm_pkg::bone_id_t id_q;

	// Run state.
	logic [CNT_W-1:0] used_q;
	logic             ovf_q;

	// Scan pointer and the one-deep read pipeline behind it. The read port is
	// registered, so the compare always looks at the entry read in the cycle before.
	logic [CNT_W-1:0]  ptr_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	drm_pkg::bone_id_t rd_data_s1;

	// Outcome of the scan.
	logic             hit_q;
	logic [IDX_W-1:0] pos_q;

	// Output register.
	logic                  out_vld_q;
	drm_pkg::dense_id_t    out_dense_q;
	logic                  out_found_q;
	logic                  out_new_q;
	logic                  out_ovf_q;
	drm_pkg::entry_count_t out_count_q;

	logic accept;
	logic issue;
	logic hit_now;
	logic done_fire;
	logic is_clear;
	logic is_remap;
	logic full;
	logic do_insert;

	assign accept   = req.valid && req.ready;
	assign is_clear = (act_q == drm_pkg::ACT_CLEAR);
	assign is_remap = (act_q == drm_pkg::ACT_REMAP);
	assign full     = (used_q >= CNT_W'(TABLE_DEPTH));

	// An insert happens only when the result is committed, after a miss.
	assign do_insert = done_fire && is_remap && !hit_q && !full;

	// Sequencer: next state and handshake strobes.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		issue     = 1'b0;
		hit_now   = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			drm_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req.action == drm_pkg::ACT_CLEAR) ? drm_pkg::ST_DONE
						: drm_pkg::ST_SCAN;
				end
			end
			drm_pkg::ST_SCAN: begin
				// The single comparator checks one stored entry per cycle.
				issue   = (ptr_q < used_q);
				hit_now = cmp_vld_s1 && (rd_data_s1 == id_q);
				if (hit_now) begin
					state_d = drm_pkg::ST_DONE;
				end else if (!issue && !cmp_vld_s1) begin
					// Every filled entry has been compared without a match.
					state_d = drm_pkg::ST_DONE;
				end
			end
			drm_pkg::ST_DONE: begin
				// Commit once the output register is free or is being emptied.
				done_fire = !out_vld_q || rsp.ready;
				if (done_fire) begin
					state_d = drm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = drm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			id_q  <= req.bone_id;
		end
	end

	// Scan pointer, read pipeline valid and hit record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			if (accept) begin
				ptr_q      <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				cmp_vld_s1 <= issue && !hit_now;
				if (hit_now) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) begin
			pos_q <= cmp_idx_s1;
		end
		if (issue) begin
			cmp_idx_s1 <= ptr_q[IDX_W-1:0];
		end
	end

	// Table memory: one registered read port for the scan, one write port for
	// inserts at the next free position.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= id_mem[ptr_q[IDX_W-1:0]];
		end
		if (do_insert) begin
			id_mem[used_q[IDX_W-1:0]] <= id_q;
		end
	end

	// Run state: the entry count and the sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ovf_q  <= 1'b0;
		end else if (done_fire) begin
			if (is_clear) begin
				used_q <= '0;
				ovf_q  <= 1'b0;
			end else if (do_insert) begin
				used_q <= used_q + CNT_W'(1);
			end else if (is_remap && !hit_q) begin
				// A new identifier while the table is full is dropped.
				ovf_q <= 1'b1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_fire) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output payload reflects the run state after this beat.
	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_dense_q <= '0;
			out_found_q <= 1'b0;
			out_new_q   <= 1'b0;
			out_ovf_q   <= ovf_q;
			out_count_q <= drm_pkg::EntryCountWidth'(used_q);
			if (is_clear) begin
				out_ovf_q   <= 1'b0;
				out_count_q <= '0;
			end else if (hit_q) begin
				out_dense_q <= drm_pkg::DenseIdWidth'(pos_q);
				out_found_q <= 1'b1;
			end else if (is_remap) begin
				if (!full) begin
					out_dense_q <= drm_pkg::DenseIdWidth'(used_q[IDX_W-1:0]);
					out_found_q <= 1'b1;
					out_new_q   <= 1'b1;
					out_count_q <= drm_pkg::EntryCountWidth'(used_q + CNT_W'(1));
				end else begin
					out_ovf_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.dense_id    = out_dense_q;
	assign rsp.found       = out_found_q;
	assign rsp.was_new     = out_new_q;
	assign rsp.overflow    = out_ovf_q;
	assign rsp.entry_count = out_count_q;

endmodule

[rtl/core/drm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense id remapper checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module drm_props #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input drm_pkg::dense_id_t    rsp_dense_id,
	input logic                  rsp_found,
	input logic                  rsp_was_new,
	input logic                  rsp_overflow,
	input drm_pkg::entry_count_t rsp_entry_count
);

	// A stalled result beat holds its dense id, found flag and entry count.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dense_id)
			&& $stable(rsp_found) && $stable(rsp_entry_count))
		else $error("response changed while stalled");

	// A miss reports dense id zero, and a hit needs at least one stored entry.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_found || rsp_dense_id == '0)
			&& (!rsp_found || rsp_entry_count != '0))
		else $error("inconsistent found, dense id and entry count");

	// An insert is a hit that cannot coexist with overflow, which needs a full table.
	a_new_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_was_new |-> rsp_found && !rsp_overflow
			&& (drm_pkg::EntryCountWidth'(rsp_dense_id) + 9'd1 == rsp_entry_count))
		else $error("inserted entry does not sit at the end of the table");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_count <= drm_pkg::EntryCountWidth'(TABLE_DEPTH)
			&& (!rsp_overflow || rsp_entry_count == drm_pkg::EntryCountWidth'(TABLE_DEPTH)))
		else $error("entry count out of range or overflow before full");

endmodule

bind dense_id_remapper_top drm_props #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_drm_props (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_dense_id    (rsp.dense_id),
	.rsp_found       (rsp.found),
	.rsp_was_new     (rsp.was_new),
	.rsp_overflow    (rsp.overflow),
	.rsp_entry_count (rsp.entry_count)
);
